### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the locally connected sigmoid layer; empty when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCSL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcsl: implication check failed");
`define LCSL_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lcsl: invariant check failed");
`else
`define LCSL_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCSL_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

### hdl/lcsl_pkg.sv
// ---------------------------------------------------------------------------
// lcsl_pkg
// Shared widths, word types and table-building helpers for the
// locally connected sigmoid layer.
// ---------------------------------------------------------------------------
package lcsl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int ACT_W    = 16;
  localparam int PROD_W   = 32;

  // output buffer, power of two
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CREDIT_MAX = CNT_W'(FIFO_DEPTH);

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [ACT_W-1:0] activation;
    logic             last;
  } res_t;

  // (a*b) >> 62, a and b below 2^63
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[125:62];
  endfunction

  // restoring divide, used only while building constant tables
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q62 for 0 <= f <= 1, alternating series
  function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
    logic [63:0] term;
    logic [63:0] total;
    term  = ONE_Q62;
    total = ONE_Q62;
    for (int k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        term = div_u64(mul_q62(term, f), 64'(k));
        if (k[0]) begin
          total = total - term;
        end else begin
          total = total + term;
        end
      end
    end
    return total;
  endfunction

endpackage

### hdl/lcsl_if.sv
// ---------------------------------------------------------------------------
// lcsl_in_if / lcsl_out_if
// Valid/ready channels for sample words and activation words.
// ---------------------------------------------------------------------------
interface lcsl_in_if;
  logic                                valid;
  logic                                ready;
  logic        [lcsl_pkg::SAMPLE_W-1:0] sample;
  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_oldest;
  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_middle;
  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_newest;
  logic                                last_sample;

  modport source (
    output valid, sample, weight_oldest, weight_middle, weight_newest, last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample, weight_oldest, weight_middle, weight_newest, last_sample,
    output ready
  );
endinterface

interface lcsl_out_if;
  logic                           valid;
  logic                           ready;
  logic [lcsl_pkg::ACT_W-1:0]     activation;
  logic                           last_output;

  modport source (
    output valid, activation, last_output,
    input  ready
  );
  modport sink (
    input  valid, activation, last_output,
    output ready
  );
endinterface

### hdl/lcsl_ram.sv
// ---------------------------------------------------------------------------
// lcsl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lcsl_ram #(
  parameter  int WIDTH  = 16,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lcsl_sig_table.sv
// ---------------------------------------------------------------------------
// lcsl_sig_table
// Sigmoid lookup RAM plus the fill sequencer that loads it after reset.
// ---------------------------------------------------------------------------
module lcsl_sig_table #(
  parameter  int SIGMOID_ENTRIES = 1024,
  localparam int ADDR_W          = $clog2(SIGMOID_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [lcsl_pkg::ACT_W-1:0]  rd_data,
  output logic                        filled
);

  typedef logic [lcsl_pkg::ACT_W-1:0] table_t [SIGMOID_ENTRIES];

  // round(65535/(1+exp(-c))) at the midpoint c of entry i
  function automatic logic [lcsl_pkg::ACT_W-1:0] rom_entry(int unsigned i);
    logic [63:0] odd, num, scaled, whole, r, q1, rem1, q2, frac;
    logic [63:0] e, e1, e46, den, top, v;
    logic        positive;
    odd      = 64'(2 * i + 1);
    positive = odd >= 64'(SIGMOID_ENTRIES);
    num      = positive ? odd - 64'(SIGMOID_ENTRIES) : 64'(SIGMOID_ENTRIES) - odd;
    scaled   = num * 64'd8;
    whole    = scaled / SIGMOID_ENTRIES;
    r        = scaled % SIGMOID_ENTRIES;
    q1       = (r << 32) / SIGMOID_ENTRIES;
    rem1     = (r << 32) % SIGMOID_ENTRIES;
    q2       = (rem1 << 30) / SIGMOID_ENTRIES;
    frac     = (q1 << 30) + q2;
    e        = lcsl_pkg::exp_neg_frac(frac);
    e1       = lcsl_pkg::exp_neg_frac(lcsl_pkg::ONE_Q62);
    for (int n = 0; n < 16; n++) begin
      if (64'(n) < whole) begin
        e = lcsl_pkg::mul_q62(e, e1);
      end
    end
    e46 = (e + 64'd32768) >> 16;
    den = (64'd1 << 46) + e46;
    top = positive ? (64'd1 << 46) : e46;
    v   = lcsl_pkg::div_u64(64'd131070 * top + den, den << 1);
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[lcsl_pkg::ACT_W-1:0];
  endfunction

  function automatic table_t build_table();
    table_t t;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      t[i] = rom_entry(i);
    end
    return t;
  endfunction

  localparam table_t SIG_TABLE = build_table();

  logic [ADDR_W:0]               fill_cnt;
  logic                          fill_we;
  logic [ADDR_W-1:0]             fill_addr;
  logic [lcsl_pkg::ACT_W-1:0]    fill_data;
  logic                          fill_busy;

  assign fill_busy = fill_cnt != (ADDR_W + 1)'(SIGMOID_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      fill_we  <= 1'b0;
      filled   <= 1'b0;
    end else begin
      fill_we <= fill_busy;
      if (fill_busy) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      // set once the final write has gone in
      filled <= !fill_busy && !fill_we;
    end
  end

  always_ff @(posedge clk) begin
    fill_addr <= fill_cnt[ADDR_W-1:0];
    fill_data <= SIG_TABLE[fill_cnt[ADDR_W-1:0]];
  end

  lcsl_ram #(
    .WIDTH (lcsl_pkg::ACT_W),
    .DEPTH (SIGMOID_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

### hdl/lcsl_mac.sv
// ---------------------------------------------------------------------------
// lcsl_mac
// Four-stage window datapath: capture, products, partial sums, final sum
// with clamp; emits the sigmoid table index.
// ---------------------------------------------------------------------------
module lcsl_mac #(
  parameter  int SIGMOID_ENTRIES = 1024,
  localparam int ADDR_W          = $clog2(SIGMOID_ENTRIES)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  logic                                 last,
  input  logic        [lcsl_pkg::SAMPLE_W-1:0] older,
  input  logic        [lcsl_pkg::SAMPLE_W-1:0] newer,
  input  logic        [lcsl_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_oldest,
  input  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_middle,
  input  logic signed [lcsl_pkg::WEIGHT_W-1:0] weight_newest,
  input  logic signed [lcsl_pkg::WEIGHT_W-1:0] bias,
  output lcsl_pkg::ctl_t                       idx_ctl,
  output logic        [ADDR_W-1:0]             idx
);

  localparam int SCALE_W = 32 + $clog2(SIGMOID_ENTRIES + 1);

  lcsl_pkg::ctl_t s1_ctl, s2_ctl, s3_ctl;

  logic        [lcsl_pkg::SAMPLE_W-1:0] s1_older, s1_newer, s1_sample;
  logic signed [lcsl_pkg::WEIGHT_W-1:0] s1_w_old, s1_w_mid, s1_w_new;

  logic signed [lcsl_pkg::PROD_W:0]   prod_old, prod_mid, prod_new;
  logic        [lcsl_pkg::PROD_W-1:0] p_old, p_mid, p_new;

  logic [lcsl_pkg::PROD_W:0]   part_a, part_b;
  logic [lcsl_pkg::PROD_W:0]   part_a_next, part_b_next;
  logic [lcsl_pkg::PROD_W+1:0] total;
  logic [lcsl_pkg::PROD_W-1:0] u, u_next;
  logic [SCALE_W-1:0]          scaled;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      s3_ctl  <= '0;
      idx_ctl <= '0;
    end else begin
      s1_ctl  <= '{valid: fire, last: last};
      s2_ctl  <= s1_ctl;
      s3_ctl  <= s2_ctl;
      idx_ctl <= s3_ctl;
    end
  end

  // stage 1: capture window and weights
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_older  <= older;
      s1_newer  <= newer;
      s1_sample <= sample;
      s1_w_old  <= weight_oldest;
      s1_w_mid  <= weight_middle;
      s1_w_new  <= weight_newest;
    end
  end

  // stage 2: unsigned Q0.16 x signed Q4.12 -> signed Q4.28, always fits 32 bits
  assign prod_old = $signed({1'b0, s1_older})  * s1_w_old;
  assign prod_mid = $signed({1'b0, s1_newer})  * s1_w_mid;
  assign prod_new = $signed({1'b0, s1_sample}) * s1_w_new;

  always_ff @(posedge clk) begin
    p_old <= prod_old[lcsl_pkg::PROD_W-1:0];
    p_mid <= prod_mid[lcsl_pkg::PROD_W-1:0];
    p_new <= prod_new[lcsl_pkg::PROD_W-1:0];
  end

  // stage 3: two partial sums, bias moved to Q4.28
  assign part_a_next = {p_old[lcsl_pkg::PROD_W-1], p_old} + {p_mid[lcsl_pkg::PROD_W-1], p_mid};
  assign part_b_next = {p_new[lcsl_pkg::PROD_W-1], p_new}
                     + {bias[lcsl_pkg::WEIGHT_W-1], bias, 16'd0};

  always_ff @(posedge clk) begin
    part_a <= part_a_next;
    part_b <= part_b_next;
  end

  // stage 4: final sum, clamp to [-2^31, 2^31-1] and offset by 2^31
  assign total = {part_a[lcsl_pkg::PROD_W], part_a} + {part_b[lcsl_pkg::PROD_W], part_b};

  always_comb begin
    priority if (total[33:31] == 3'b000 || total[33:31] == 3'b111) begin
      u_next = {~total[31], total[30:0]};
    end else if (total[33]) begin
      u_next = '0;
    end else begin
      u_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    u <= u_next;
  end

  // index = floor(u * entries / 2^32), always below entries
  assign scaled = SCALE_W'(u) * SCALE_W'(SIGMOID_ENTRIES);
  assign idx    = scaled[32 +: ADDR_W];

endmodule

### hdl/lcsl_out_fifo.sv
// ---------------------------------------------------------------------------
// lcsl_out_fifo
// Small result buffer between the datapath and the output channel.
// Overflow is prevented upstream by the credit counter.
// ---------------------------------------------------------------------------
module lcsl_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcsl_pkg::res_t push_word,
  input  logic           pop,
  output lcsl_pkg::res_t head,
  output logic           not_empty
);

  lcsl_pkg::res_t mem [lcsl_pkg::FIFO_DEPTH];

  logic [lcsl_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [lcsl_pkg::CNT_W-1:0] count;

  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

### hdl/local_conv_sigmoid_layer.sv
// ---------------------------------------------------------------------------
// local_conv_sigmoid_layer
// Streaming three-tap locally connected layer with sigmoid activation.
// ---------------------------------------------------------------------------
// Usage:
//   din carries one sample word with the three weights of the output that
//   sample completes, plus last_sample. Once two earlier samples of the run
//   are held, each word yields one activation word on dout; the first two
//   words of a run (or a run shorter than three) give none. last_sample
//   clears the window and is echoed as last_output.
//   bias_we/bias_wdata write the signed Q4.12 bias; write only while idle.
//   Throughput: one word per cycle, sustained while dout.ready stays high.
//   Path: a result word is presented on dout once its accepted input word
//   has passed capture on accept, three more datapath stages, the table
//   read and the buffer write.
//   Reset: window and bias clear, then the sigmoid table is loaded, one
//   entry per cycle; din.ready stays low until the table is filled.
//   Stall: results wait in an 8-word output buffer. A credit counter covers
//   words in flight plus buffered; din.ready drops when it reaches 8.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module local_conv_sigmoid_layer #(
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 bias_we,
  input  logic signed [lcsl_pkg::WEIGHT_W-1:0] bias_wdata,
  lcsl_in_if.sink                              din,
  lcsl_out_if.source                           dout
);

  localparam int ADDR_W = $clog2(SIGMOID_ENTRIES);

  logic signed [lcsl_pkg::WEIGHT_W-1:0] bias;
  logic        [lcsl_pkg::SAMPLE_W-1:0] older_sample, newer_sample;
  logic        [1:0]                    fill_count;

  logic accept;
  logic fire;
  logic pop;
  logic table_filled;

  logic [lcsl_pkg::CNT_W-1:0] credit_cnt, credit_next;

  lcsl_pkg::ctl_t             idx_ctl;
  lcsl_pkg::ctl_t             ram_ctl;
  logic [ADDR_W-1:0]          idx;
  logic [lcsl_pkg::ACT_W-1:0] act_data;
  lcsl_pkg::res_t             push_word;
  lcsl_pkg::res_t             head;
  logic                       not_empty;

  assign accept    = din.valid && din.ready;
  assign fire      = accept && fill_count[1];
  assign pop       = dout.valid && dout.ready;
  assign din.ready = table_filled && (credit_cnt < lcsl_pkg::CREDIT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (bias_we) begin
      bias <= bias_wdata;
    end
  end

  // sliding window
  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newer_sample <= '0;
      fill_count   <= '0;
    end else if (accept) begin
      if (din.last_sample) begin
        older_sample <= '0;
        newer_sample <= '0;
        fill_count   <= '0;
      end else begin
        older_sample <= newer_sample;
        newer_sample <= din.sample;
        if (!fill_count[1]) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // credits: result words in flight plus buffered
  always_comb begin
    credit_next = credit_cnt;
    if (fire && !pop) begin
      credit_next = credit_cnt + 1'b1;
    end else if (pop && !fire) begin
      credit_next = credit_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_cnt <= '0;
      ram_ctl    <= '0;
    end else begin
      credit_cnt <= credit_next;
      ram_ctl    <= idx_ctl;
    end
  end

  lcsl_mac #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .last          (din.last_sample),
    .older         (older_sample),
    .newer         (newer_sample),
    .sample        (din.sample),
    .weight_oldest (din.weight_oldest),
    .weight_middle (din.weight_middle),
    .weight_newest (din.weight_newest),
    .bias          (bias),
    .idx_ctl       (idx_ctl),
    .idx           (idx)
  );

  lcsl_sig_table #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (idx_ctl.valid),
    .rd_addr (idx),
    .rd_data (act_data),
    .filled  (table_filled)
  );

  assign push_word.activation = act_data;
  assign push_word.last       = ram_ctl.last;

  lcsl_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ram_ctl.valid),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  assign dout.valid       = not_empty;
  assign dout.activation  = head.activation;
  assign dout.last_output = head.last;

  // a firing word reaches the table output after the four datapath stages and the table read
  `LCSL_ASSERT_IMP(a_fire_latency, clk, rst, fire, ##5 ram_ctl.valid)
  // every buffer write is covered by a credit taken at fire
  `LCSL_ASSERT_IMP(a_push_has_credit, clk, rst, ram_ctl.valid, credit_cnt != '0)
  `LCSL_ASSERT_ALWAYS(a_credit_bound, clk, rst, credit_cnt <= lcsl_pkg::CREDIT_MAX)
  `LCSL_ASSERT_IMP(a_window_clear, clk, rst, accept && din.last_sample, ##1 fill_count == 2'd0)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the three-tap locally connected sigmoid layer.
// Sample words go in over valid/ready; a local window model with its own
// sigmoid table predicts every activation word, and a checker compares them
// in order. Covers short runs, saturation, several bias settings, random
// idling on both sides, a steady stretch and a long output stall.
// ---------------------------------------------------------------------------
module tb;

  localparam int TABLE_ENTRIES  = 1024;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam longint SUM_LO = -(longint'(1) << 31);
  localparam longint SUM_HI = (longint'(1) << 31) - 1;

  typedef struct {
    logic        [lcsl_pkg::SAMPLE_W-1:0] sample;
    logic signed [lcsl_pkg::WEIGHT_W-1:0] w_oldest;
    logic signed [lcsl_pkg::WEIGHT_W-1:0] w_middle;
    logic signed [lcsl_pkg::WEIGHT_W-1:0] w_newest;
    logic                                 last;
  } tap_word_t;

  logic clk = 1'b0;
  logic rst;
  logic bias_we;
  logic signed [lcsl_pkg::WEIGHT_W-1:0] bias_wdata;

  lcsl_in_if  tap_in ();
  lcsl_out_if act_out ();

  local_conv_sigmoid_layer #(
    .SIGMOID_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .bias_we    (bias_we),
    .bias_wdata (bias_wdata),
    .din        (tap_in),
    .dout       (act_out)
  );

  always #2 clk = ~clk;

  // window model
  logic [lcsl_pkg::ACT_W-1:0]             sigmoid_lut [TABLE_ENTRIES];
  logic        [lcsl_pkg::SAMPLE_W-1:0]   win_older;
  logic        [lcsl_pkg::SAMPLE_W-1:0]   win_newer;
  int                                     win_fill;
  logic signed [lcsl_pkg::WEIGHT_W-1:0]   cur_bias;
  lcsl_pkg::res_t                         act_expected [$];

  int  mismatch_count = 0;
  int  samples_sent   = 0;
  int  acts_checked   = 0;
  int  runs_sent      = 0;
  int  bias_settings  = 0;
  int  idle_cycles    = 0;
  bit  src_idle_en    = 1'b1;
  bit  snk_idle_en    = 1'b1;
  bit  hold_request   = 1'b0;

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  // exp(-f), f in [0,1] as Q62, alternating Taylor series
  function automatic logic [63:0] exp_neg_q62(logic [63:0] f);
    logic [63:0] term;
    logic [63:0] total;
    term  = Q62_ONE;
    total = Q62_ONE;
    for (int k = 1; k < 40 && term != 64'd0; k++) begin
      term = q62_mul(term, f) / 64'(k);
      if (k % 2 == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    return total;
  endfunction

  // round(65535 / (1 + exp(-c))) at the midpoint c of entry idx
  function automatic logic [15:0] sigmoid_entry(int idx, logic [63:0] e_one);
    logic [63:0] odd, num, scaled, whole, r, q1, rem1, q2, frac;
    logic [63:0] e, e46, den, top, v;
    bit          positive;
    odd      = 64'(2 * idx + 1);
    positive = odd >= 64'(TABLE_ENTRIES);
    num      = positive ? odd - 64'(TABLE_ENTRIES) : 64'(TABLE_ENTRIES) - odd;
    scaled   = num * 64'd8;
    whole    = scaled / 64'(TABLE_ENTRIES);
    r        = scaled % 64'(TABLE_ENTRIES);
    q1       = (r << 32) / 64'(TABLE_ENTRIES);
    rem1     = (r << 32) % 64'(TABLE_ENTRIES);
    q2       = (rem1 << 30) / 64'(TABLE_ENTRIES);
    frac     = (q1 << 30) + q2;
    e        = exp_neg_q62(frac);
    for (int n = 0; n < whole && n < 16; n++) begin
      e = q62_mul(e, e_one);
    end
    e46 = (e + (64'd1 << 15)) >> 16;
    den = (64'd1 << 46) + e46;
    top = positive ? (64'd1 << 46) : e46;
    v   = (64'd131070 * top + den) / (64'd2 * den);
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[15:0];
  endfunction

  function automatic void predict_activation(tap_word_t w);
    lcsl_pkg::res_t res;
    longint         acc;
    longint         u;
    longint         idx;
    if (win_fill >= 2) begin
      acc = longint'(cur_bias) * 65536;
      acc += longint'(win_older) * longint'(w.w_oldest);
      acc += longint'(win_newer) * longint'(w.w_middle);
      acc += longint'(w.sample) * longint'(w.w_newest);
      if (acc < SUM_LO) begin
        acc = SUM_LO;
      end
      if (acc > SUM_HI) begin
        acc = SUM_HI;
      end
      u   = acc - SUM_LO;
      idx = (u * TABLE_ENTRIES) >>> 32;
      if (idx >= TABLE_ENTRIES) begin
        idx = TABLE_ENTRIES - 1;
      end
      res.activation = sigmoid_lut[idx];
      res.last       = w.last;
      act_expected.push_back(res);
    end
    win_older = win_newer;
    win_newer = w.sample;
    if (win_fill < 2) begin
      win_fill++;
    end
    if (w.last) begin
      win_older = '0;
      win_newer = '0;
      win_fill  = 0;
    end
  endfunction

  function automatic tap_word_t make_word(logic [15:0] s, logic signed [15:0] wo,
                                          logic signed [15:0] wm, logic signed [15:0] wn,
                                          logic last);
    tap_word_t w;
    w.sample   = s;
    w.w_oldest = wo;
    w.w_middle = wm;
    w.w_newest = wn;
    w.last     = last;
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mix of extremes, full range and small weights that land mid-table
  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0:          return 16'sh7FFF;
      1:          return 16'sh8000;
      2, 3, 4, 5: return 16'($urandom_range(0, 65535));
      default:    return 16'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic send_word(input tap_word_t w);
    @(negedge clk);
    while (src_idle_en && $urandom_range(0, 99) < 28) begin
      tap_in.valid <= 1'b0;
      @(negedge clk);
    end
    tap_in.valid         <= 1'b1;
    tap_in.sample        <= w.sample;
    tap_in.weight_oldest <= w.w_oldest;
    tap_in.weight_middle <= w.w_middle;
    tap_in.weight_newest <= w.w_newest;
    tap_in.last_sample   <= w.last;
    do @(posedge clk); while (tap_in.ready !== 1'b1);
    predict_activation(w);
    samples_sent++;
  endtask

  task automatic send_random_run(input int max_len);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, max_len);
    for (int k = 0; k < len; k++) begin
      send_word(make_word(rand_sample(), rand_weight(), rand_weight(), rand_weight(),
                          k == len - 1));
    end
    runs_sent++;
  endtask

  // drop valid, let every expected word arrive, then cover the pipeline
  task automatic wait_quiet();
    @(negedge clk);
    tap_in.valid <= 1'b0;
    while (act_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_bias(input logic signed [15:0] value);
    @(negedge clk);
    bias_we    <= 1'b1;
    bias_wdata <= value;
    @(negedge clk);
    bias_we    <= 1'b0;
    cur_bias = value;
    bias_settings++;
  endtask

  // window not full, short runs and clearing after last
  task automatic test_short_runs();
    send_word(make_word(16'h1234, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1));
    send_word(make_word(16'hFFFF, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
    send_word(make_word(16'h8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1));
    send_word(make_word(16'h4000, 16'sh1000, 16'sh1000, 16'sh1000, 1'b0));
    send_word(make_word(16'hC000, 16'sh0800, 16'shF800, 16'sh0400, 1'b0));
    send_word(make_word(16'h2000, 16'sh1000, 16'sh2000, 16'shE000, 1'b1));
    wait_quiet();
  endtask

  // both ends of the table, bias alone, bias extremes
  task automatic test_saturation();
    load_bias(16'sh7FFF);
    send_word(make_word(16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0));
    send_word(make_word(16'hFFFF, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
    send_word(make_word(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1));
    wait_quiet();
    load_bias(16'sh8000);
    send_word(make_word(16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_word(make_word(16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1));
    wait_quiet();
    load_bias(16'sh0000);
    send_word(make_word(16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_word(make_word(16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_word(make_word(16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
    send_word(make_word(16'h8000, 16'sh1000, 16'shF000, 16'sh0001, 1'b1));
    wait_quiet();
  endtask

  task automatic test_random_runs(input logic signed [15:0] bias, input int n_words);
    int stop_at;
    load_bias(bias);
    stop_at = samples_sent + n_words;
    while (samples_sent < stop_at) begin
      send_random_run(24);
    end
    wait_quiet();
  endtask

  task automatic test_steady_stream();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    load_bias(16'($urandom_range(0, 65535)));
    for (int n = 0; n < 8; n++) begin
      send_random_run(30);
    end
    wait_quiet();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // receiver stalls long enough for the output buffer and credits to fill
  task automatic test_output_stall();
    src_idle_en  = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 4; n++) begin
      send_random_run(12);
    end
    wait_quiet();
    src_idle_en = 1'b1;
  endtask

  initial begin : stim
    logic [63:0] e_one;
    rst                  = 1'b1;
    bias_we              = 1'b0;
    bias_wdata           = '0;
    tap_in.valid         = 1'b0;
    tap_in.sample        = '0;
    tap_in.weight_oldest = '0;
    tap_in.weight_middle = '0;
    tap_in.weight_newest = '0;
    tap_in.last_sample   = 1'b0;
    act_out.ready        = 1'b0;
    win_older            = '0;
    win_newer            = '0;
    win_fill             = 0;
    cur_bias             = '0;
    e_one = exp_neg_q62(Q62_ONE);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sigmoid_lut[i] = sigmoid_entry(i, e_one);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // table load after reset keeps ready low
    do @(posedge clk); while (tap_in.ready !== 1'b1);

    test_short_runs();
    test_saturation();
    test_random_runs(16'sh7FFF, 180);
    test_random_runs(16'sh8000, 180);
    test_random_runs(16'($urandom_range(0, 65535)), 180);
    test_output_stall();
    test_random_runs(16'sh0000, 180);
    test_steady_stream();
    test_random_runs(16'($urandom_range(0, 65535)), 180);

    if (act_expected.size() != 0) begin
      $display("%0d activation words never arrived", act_expected.size());
      mismatch_count += act_expected.size();
    end
    $display("sent %0d samples in %0d runs over %0d bias settings", samples_sent,
             runs_sent, bias_settings);
    $display("checked %0d activation words, %0d mismatches", acts_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        act_out.ready <= 1'b0;
      end else begin
        act_out.ready <= !(snk_idle_en && $urandom_range(0, 99) < 28);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lcsl_pkg::res_t want;
    if (!rst && act_out.valid === 1'b1 && act_out.ready === 1'b1) begin
      acts_checked++;
      if (act_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected activation word %h last %b", act_out.activation,
                   act_out.last_output);
        end
      end else begin
        want = act_expected.pop_front();
        if (act_out.activation !== want.activation || act_out.last_output !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("activation word %0d: expected %h last %b, got %h last %b",
                     acts_checked, want.activation, want.last, act_out.activation,
                     act_out.last_output);
          end
        end
      end
    end
  end

  // counts cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst || (tap_in.valid === 1'b1 && tap_in.ready === 1'b1) ||
        (act_out.valid === 1'b1 && act_out.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
